[hdl/sparse_polynomial_evaluate_unit_assert.svh]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluate unit: assertion macros
// Concurrent checks used by the RTL; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_EVALUATE_UNIT_ASSERT_SVH
`define SPARSE_POLYNOMIAL_EVALUATE_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define SPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication
`define SPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define SPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/spe_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluate unit: package
// Field widths, payload structs and sequencer states shared by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  // Field widths of the term and result payloads
  localparam int DATA_W  = 32;
  localparam int POWER_W = 16;

  // One term of the polynomial
  typedef struct packed {
    logic signed [DATA_W-1:0]  point;
    logic        [POWER_W-1:0] power;
    logic signed [DATA_W-1:0]  coefficient;
    logic                      last_term;
  } term_t;

  // Value of the polynomial at the end of a run
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     order_error;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP,
    ST_WAIT_ACC,
    ST_WAIT_SQR,
    ST_SUM,
    ST_WAIT_SUM,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[hdl/spe_mul.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluate unit: shared multiplier
// Low WIDTH bits of a product, one operand digit per cycle; the first digit
// is taken in the start cycle, so a narrow product is ready in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_mul #(
  parameter int WIDTH = spe_pkg::DATA_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic                  done,
  output logic      [WIDTH-1:0] product
);

  localparam int DIGIT = (WIDTH > 32) ? WIDTH / 2 : WIDTH;
  localparam int NDIG  = (WIDTH + DIGIT - 1) / DIGIT;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] a_sh;
  logic [WIDTH-1:0] b_sh;

  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] digit_ext;
  logic [WIDTH-1:0] partial;
  logic [WIDTH-1:0] product_next;

  // Select operands: fresh ones at start, shifted ones while stepping
  always_comb begin
    mul_x        = start ? a : a_sh;
    mul_y        = start ? b : b_sh;
    digit_ext    = WIDTH'(mul_y[DIGIT-1:0]);
    partial      = mul_x * digit_ext;
    product_next = (start ? '0 : product) + partial;
  end

  // Step through the digits of the second operand
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (NDIG == 1) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(NDIG - 1);
        end
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the partial sum and the shifted operands
  always_ff @(posedge clk) begin
    if (start || busy) begin
      product <= product_next;
      a_sh    <= mul_x << DIGIT;
      b_sh    <= mul_y >> DIGIT;
    end
  end

endmodule

`default_nettype wire

[hdl/sparse_polynomial_evaluate_unit.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluate unit
// Evaluates a sparse integer polynomial at a point, one term per transfer.
// ----------------------------------------------------------------------------
// Terms arrive in ascending power order; the point is taken from the first
// term of a run and a result is produced only for the term marked last. The
// point is raised to each power gap by square-and-multiply straight into the
// running power value, then coefficient times power value is added to the
// sum, all modulo 2^32. Every multiply goes through one shared multiplier,
// which is started in one state and written back in a wait state. An item
// is accepted, then takes one multiply for each set bit of the gap and one
// squaring for each bit below the top set bit, finds the gap used up, forms
// the coefficient product and sum, and finishes. A term that does not ascend
// goes straight to finish; it is skipped and flags the run. A new term is
// taken while the previous result still waits; a closing term holds in its
// finish state for as long as an earlier result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_polynomial_evaluate_unit_assert.svh"

module sparse_polynomial_evaluate_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            term_valid,
  output logic                 term_stall,
  input  wire spe_pkg::term_t  term,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output spe_pkg::result_t     result
);

  localparam int DW = spe_pkg::DATA_W;
  localparam int PW = spe_pkg::POWER_W;

  spe_pkg::state_t state;
  spe_pkg::state_t state_next;

  // Run state
  logic [DW-1:0] running_sum;
  logic [DW-1:0] power_value;
  logic [PW-1:0] previous_power;
  logic [DW-1:0] held_point;
  logic          run_started;
  logic          error_seen;

  // Per-term working registers
  logic [DW-1:0] base;
  logic [PW-1:0] gap;
  logic [PW-1:0] pw_q;
  logic [DW-1:0] coef_q;
  logic          last_q;

  // Shared multiplier
  logic          mul_start;
  logic [DW-1:0] mul_a;
  logic [DW-1:0] mul_b;
  logic          mul_done;
  logic [DW-1:0] mul_product;

  logic          term_xfer;
  logic          take;
  logic [DW-1:0] point_eff;
  logic [PW-1:0] prev_eff;
  logic          result_free;
  logic          close_run;

  assign term_xfer   = term_valid && !term_stall;
  assign take        = !run_started || (term.power > previous_power);
  assign point_eff   = run_started ? held_point : term.point;
  assign prev_eff    = run_started ? previous_power : '0;
  assign result_free = !result_valid || !result_stall;
  assign close_run   = (state == spe_pkg::ST_FINISH) && last_q && result_free;

  spe_mul #(
    .WIDTH (DW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      spe_pkg::ST_IDLE: begin
        if (term_xfer) begin
          state_next = take ? spe_pkg::ST_EXP : spe_pkg::ST_FINISH;
        end
      end
      spe_pkg::ST_EXP: begin
        if (gap == '0) begin
          state_next = spe_pkg::ST_SUM;
        end else if (gap[0]) begin
          state_next = spe_pkg::ST_WAIT_ACC;
        end else begin
          state_next = spe_pkg::ST_WAIT_SQR;
        end
      end
      spe_pkg::ST_WAIT_ACC: begin
        if (mul_done) begin
          state_next = spe_pkg::ST_EXP;
        end
      end
      spe_pkg::ST_WAIT_SQR: begin
        if (mul_done) begin
          state_next = spe_pkg::ST_EXP;
        end
      end
      spe_pkg::ST_SUM: begin
        state_next = spe_pkg::ST_WAIT_SUM;
      end
      spe_pkg::ST_WAIT_SUM: begin
        if (mul_done) begin
          state_next = spe_pkg::ST_FINISH;
        end
      end
      spe_pkg::ST_FINISH: begin
        if (!last_q || result_free) begin
          state_next = spe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spe_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: input stall and multiplier commands
  always_comb begin
    term_stall = 1'b1;
    mul_start  = 1'b0;
    mul_a      = base;
    mul_b      = base;
    case (state)
      spe_pkg::ST_IDLE: begin
        term_stall = 1'b0;
      end
      spe_pkg::ST_EXP: begin
        if (gap != '0) begin
          mul_start = 1'b1;
          if (gap[0]) begin
            mul_a = power_value;
          end
        end
      end
      spe_pkg::ST_SUM: begin
        mul_start = 1'b1;
        mul_a     = coef_q;
        mul_b     = power_value;
      end
      default: begin
        term_stall = 1'b1;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: raise on closing a run, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (close_run) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Run state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      power_value    <= DW'(1);
      previous_power <= '0;
      held_point     <= '0;
      run_started    <= 1'b0;
      error_seen     <= 1'b0;
    end else begin
      case (state)
        spe_pkg::ST_IDLE: begin
          if (term_xfer) begin
            if (!run_started) begin
              held_point     <= term.point;
              run_started    <= 1'b1;
              previous_power <= '0;
              power_value    <= DW'(1);
              running_sum    <= '0;
            end
            if (!take) begin
              error_seen <= 1'b1;
            end
          end
        end
        spe_pkg::ST_WAIT_ACC: begin
          if (mul_done) begin
            power_value <= mul_product;
          end
        end
        spe_pkg::ST_WAIT_SUM: begin
          if (mul_done) begin
            running_sum    <= running_sum + mul_product;
            previous_power <= pw_q;
          end
        end
        spe_pkg::ST_FINISH: begin
          // Close the run and clear back to the reset values
          if (close_run) begin
            running_sum    <= '0;
            power_value    <= DW'(1);
            previous_power <= '0;
            held_point     <= '0;
            run_started    <= 1'b0;
            error_seen     <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      spe_pkg::ST_IDLE: begin
        if (term_xfer) begin
          gap    <= term.power - prev_eff;
          base   <= point_eff;
          pw_q   <= term.power;
          coef_q <= term.coefficient;
          last_q <= term.last_term;
        end
      end
      spe_pkg::ST_WAIT_ACC: begin
        if (mul_done) begin
          gap[0] <= 1'b0;
        end
      end
      spe_pkg::ST_WAIT_SQR: begin
        if (mul_done) begin
          base <= mul_product;
          gap  <= gap >> 1;
        end
      end
      spe_pkg::ST_FINISH: begin
        if (close_run) begin
          result.value       <= running_sum;
          result.order_error <= error_seen;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `SPE_ASSERT_IMPL(a_done_in_wait, clk, rst, mul_done,
                   (state == spe_pkg::ST_WAIT_ACC) || (state == spe_pkg::ST_WAIT_SQR) ||
                   (state == spe_pkg::ST_WAIT_SUM))
  `SPE_ASSERT_IMPL(a_square_has_high_bits, clk, rst,
                   (state == spe_pkg::ST_WAIT_SQR) && mul_done, gap[PW-1:1] != '0)
  `SPE_ASSERT_NEXT(a_skip_keeps_sum, clk, rst,
                   term_xfer && run_started && (term.power <= previous_power),
                   error_seen && $stable(running_sum) && (state == spe_pkg::ST_FINISH))
  `SPE_ASSERT_NEXT(a_run_closes, clk, rst, close_run,
                   result_valid && !run_started && !error_seen)

endmodule

`default_nettype wire

[tb/sparse_polynomial_evaluate_unit_test.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluate unit: self-checking testbench
// Sends term transfers to the unit and predicts each polynomial value in step.
// A short directed table covers the extreme fields, wrap-around and order
// faults. Random runs follow: mostly ascending terms, with some
// non-ascending ones. Both sides idle at random. Results are checked field by
// field, in order, against the queue of predicted values.
// ----------------------------------------------------------------------------
module sparse_polynomial_evaluate_unit_test;

  localparam int DATA_W       = spe_pkg::DATA_W;
  localparam int POWER_W      = spe_pkg::POWER_W;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_TERMS = 1800;
  localparam int MAX_WAIT     = 8;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TOP_POWER    = (1 << POWER_W) - 1;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    spe_pkg::term_t   t;
    logic             typed;
    spe_pkg::result_t want;
  } directed_row_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             term_valid   = 1'b0;
  spe_pkg::term_t   term         = '0;
  logic             result_stall = 1'b0;
  logic             term_stall;
  logic             result_valid;
  spe_pkg::result_t result;

  int               mismatches  = 0;
  int               cycle_count = 0;
  spe_pkg::result_t pending_values[$];

  // Predicted evaluator state
  logic [DATA_W-1:0]  poly_sum         = '0;
  logic [DATA_W-1:0]  poly_power_value = 1;
  logic [DATA_W-1:0]  poly_point       = '0;
  logic [POWER_W-1:0] poly_prev_power  = '0;
  logic               poly_open        = 1'b0;
  logic               poly_order_bad   = 1'b0;

  sparse_polynomial_evaluate_unit dut (
    .clk          (clk),
    .rst          (rst),
    .term_valid   (term_valid),
    .term_stall   (term_stall),
    .term         (term),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sparse_polynomial_evaluate_unit regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Fold one term into the running evaluation; return 1 when it closes a run
  function automatic bit apply_term(input spe_pkg::term_t t, output spe_pkg::result_t r);
    logic [DATA_W-1:0]  base;
    logic [DATA_W-1:0]  raised;
    logic [POWER_W-1:0] gap;
    bit                 take;
    take = 1'b1;
    r    = '0;
    if (!poly_open) begin
      poly_point       = t.point;
      poly_open        = 1'b1;
      poly_prev_power  = '0;
      poly_power_value = 1;
      poly_sum         = '0;
    end else if (t.power <= poly_prev_power) begin
      poly_order_bad = 1'b1;
      take           = 1'b0;
    end
    if (take) begin
      // raise the point to the power gap by square-and-multiply
      gap    = t.power - poly_prev_power;
      base   = poly_point;
      raised = 1;
      while (gap != 0) begin
        if (gap[0]) raised = raised * base;
        gap  = gap >> 1;
        base = base * base;
      end
      poly_power_value = poly_power_value * raised;
      poly_sum         = poly_sum + t.coefficient * poly_power_value;
      poly_prev_power  = t.power;
    end
    if (!t.last_term) return 1'b0;
    r.value       = poly_sum;
    r.order_error = poly_order_bad;
    poly_sum         = '0;
    poly_power_value = 1;
    poly_point       = '0;
    poly_prev_power  = '0;
    poly_open        = 1'b0;
    poly_order_bad   = 1'b0;
    return 1'b1;
  endfunction

  // Idle, offer one term, hold it until the transfer, then predict
  task automatic send_term(input spe_pkg::term_t t, input int idle_cycles,
                           input logic typed, input spe_pkg::result_t want);
    spe_pkg::result_t predicted;
    repeat (idle_cycles) begin
      term_valid <= 1'b0;
      @(posedge clk);
    end
    term       <= t;
    term_valid <= 1'b1;
    @(posedge clk);
    while (term_stall) @(posedge clk);
    if (apply_term(t, predicted)) pending_values.push_back(typed ? want : predicted);
  endtask

  function automatic directed_row_t term_row(input logic [DATA_W-1:0] point,
                                             input int power,
                                             input logic [DATA_W-1:0] coefficient,
                                             input logic last_term, input logic typed,
                                             input logic [DATA_W-1:0] value,
                                             input logic order_error);
    directed_row_t row;
    row.t.point          = point;
    row.t.power          = power[POWER_W-1:0];
    row.t.coefficient    = coefficient;
    row.t.last_term      = last_term;
    row.typed            = typed;
    row.want.value       = value;
    row.want.order_error = order_error;
    return row;
  endfunction

  // Take results, stalling for a random count before each one
  initial begin
    int n;
    bit calm_rx;
    calm_rx = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 5) == 0) calm_rx = !calm_rx;
      n = calm_rx ? 0 : $urandom_range(0, MAX_WAIT);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    spe_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("result value %0h error %0b with nothing pending",
                                  result.value, result.order_error));
      end else begin
        want = pending_values.pop_front();
        if (result.value !== want.value)
          report_mismatch($sformatf("value %0h, predicted %0h", result.value, want.value));
        if (result.order_error !== want.order_error)
          report_mismatch($sformatf("order_error %0b, predicted %0b",
                                    result.order_error, want.order_error));
      end
    end
  end

  initial begin
    directed_row_t     rows[$];
    spe_pkg::term_t    t;
    int                sent;
    int                run_len;
    int                top_power;
    int                pw;
    int                k;
    bit                calm;
    logic [DATA_W-1:0] pt;

    //                   point         power  coefficient   last typed value         err
    rows.push_back(term_row(32'd123,      0,     32'd5,        1, 1, 32'd5,          0));
    rows.push_back(term_row(32'd0,        0,     32'd7,        1, 1, 32'd7,          0));
    rows.push_back(term_row(32'd0,        5,     32'd7,        1, 1, 32'd0,          0));
    rows.push_back(term_row(32'd2,        31,    32'd1,        1, 1, 32'h8000_0000,  0));
    rows.push_back(term_row(32'd2,        32,    32'd1,        1, 1, 32'd0,          0));
    rows.push_back(term_row(32'hFFFF_FFFF, 65535, 32'd1,       1, 1, 32'hFFFF_FFFF,  0));
    rows.push_back(term_row(32'h7FFF_FFFF, 1,    32'd1,        1, 1, 32'h7FFF_FFFF,  0));
    rows.push_back(term_row(32'h8000_0000, 1,  32'hFFFF_FFFF,  1, 1, 32'h8000_0000,  0));
    // dense run 1 + x + x^2 at two
    rows.push_back(term_row(32'd2,        0,     32'd1,        0, 0, 32'd0,          0));
    rows.push_back(term_row(32'd99,       1,     32'd1,        0, 0, 32'd0,          0));
    rows.push_back(term_row(32'd99,       2,     32'd1,        1, 1, 32'd7,          0));
    // repeated power: skipped and flagged
    rows.push_back(term_row(32'd3,        2,     32'd1,        0, 0, 32'd0,          0));
    rows.push_back(term_row(32'd3,        2,     32'd7,        1, 1, 32'd9,          1));
    // falling power in mid-run, then recovery
    rows.push_back(term_row(32'd5,        10,  32'h1234_5678,  0, 0, 32'd0,          0));
    rows.push_back(term_row(32'd5,        4,   32'h0BAD_F00D,  0, 0, 32'd0,          0));
    rows.push_back(term_row(32'd5,        11,  32'hFEDC_BA98,  1, 0, 32'd0,          0));
    // widest gap with extreme coefficients
    rows.push_back(term_row(32'hFFFF_FFFD, 0,  32'h7FFF_FFFF,  0, 0, 32'd0,          0));
    rows.push_back(term_row(32'h0000_0000, 65535, 32'hFFFF_FFFF, 1, 0, 32'd0,        0));
    // alternating bit patterns in power and coefficient, closing with all ones
    rows.push_back(term_row(32'hDEAD_BEEF, 16'h5555, 32'h5A5A_5A5A, 0, 0, 32'd0,     0));
    rows.push_back(term_row(32'h2152_4110, 16'hAAAA, 32'hA5A5_A5A5, 0, 0, 32'd0,     0));
    rows.push_back(term_row(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 32'd0,     0));
    // zero power repeated at the start of a run
    rows.push_back(term_row(32'd7,        0,     32'd0,        0, 0, 32'd0,          0));
    rows.push_back(term_row(32'd7,        0,     32'd3,        1, 1, 32'd0,          1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (rows[i]) send_term(rows[i].t, $urandom_range(0, MAX_WAIT), rows[i].typed,
                                rows[i].want);

    // Random runs: mostly ascending powers, some out-of-order terms
    sent = 0;
    while (sent < RANDOM_TERMS) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      calm    = ($urandom_range(0, 7) == 0);
      pt      = ($urandom_range(0, 3) == 0) ? DATA_W'(int'($urandom_range(0, 4)) - 2)
                                            : DATA_W'($urandom);
      top_power = 0;
      for (k = 0; k < run_len; k++) begin
        if (k == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    pw = $urandom_range(0, 40);
            2, 3:    pw = $urandom_range(0, TOP_POWER);
            default: pw = $urandom_range(TOP_POWER - 35, TOP_POWER);
          endcase
          top_power = pw;
        end else if (top_power == TOP_POWER || $urandom_range(0, 9) == 0) begin
          pw = $urandom_range(0, top_power);
        end else begin
          if ($urandom_range(0, 3) == 0)
            pw = top_power + $urandom_range(1, TOP_POWER - top_power);
          else
            pw = top_power + $urandom_range(1, (TOP_POWER - top_power < 20) ?
                                               TOP_POWER - top_power : 20);
          top_power = pw;
        end
        t.point       = (k == 0) ? pt : DATA_W'($urandom);
        t.power       = pw[POWER_W-1:0];
        t.coefficient = ($urandom_range(0, 4) == 0) ? DATA_W'(int'($urandom_range(0, 16)) - 8)
                                                    : DATA_W'($urandom);
        t.last_term   = (k == run_len - 1);
        send_term(t, calm ? 0 : $urandom_range(0, MAX_WAIT), 1'b0, '0);
        sent++;
      end
    end
    term_valid <= 1'b0;

    // Drain the outstanding results, then allow for stray ones
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("sparse_polynomial_evaluate_unit regression: pass");
    end else begin
      $display("sparse_polynomial_evaluate_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/spe_pkg.sv
hdl/spe_mul.sv
hdl/sparse_polynomial_evaluate_unit.sv
tb/sparse_polynomial_evaluate_unit_test.sv
